FILE: src/c2p_pkg.sv
// Shared types, constants and the arctangent table of the Cartesian-to-polar converter.
// It depends on nothing. Every module of the converter imports it.
`default_nettype none
package c2p_pkg;

    // Width of the signed CORDIC vector datapath and of the angle accumulator.
    localparam int CORDIC_W        = 64;
    localparam int ACC_W           = 32;
    // The magnitudes are scaled so that full scale is two to the power of this figure.
    localparam int FULL_SCALE_LOG2 = 59;

    // What the post stage does with the angle: take the CORDIC result or an exact axis value.
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_CORDIC  = 3'd0;
    localparam t_kind KIND_ZERO    = 3'd1;
    localparam t_kind KIND_HALF    = 3'd2;
    localparam t_kind KIND_QUARTER = 3'd3;
    localparam t_kind KIND_THREEQ  = 3'd4;

    // Angles on the axes, in units of 2^-32 of a turn.
    localparam logic [ACC_W-1:0] TURN_ZERO    = 32'h0000_0000;
    localparam logic [ACC_W-1:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [ACC_W-1:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [ACC_W-1:0] TURN_THREEQ  = 32'hC000_0000;

    // Control that travels beside the data from one pipeline stage to the next.
    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_ctl;

    // atan(2^-i) as a fraction of a turn, scaled by 2^32 and rounded.
    function automatic logic [ACC_W-1:0] atan_turn(input logic [4:0] idx);
        logic [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            5'd24:   v = 32'h0000_0029;
            5'd25:   v = 32'h0000_0014;
            5'd26:   v = 32'h0000_000A;
            5'd27:   v = 32'h0000_0005;
            5'd28:   v = 32'h0000_0003;
            5'd29:   v = 32'h0000_0001;
            5'd30:   v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: src/c2p_prep.sv
// Front end of the converter: squares, sum of squares, half-plane fold and axis detection.
// It depends on c2p_pkg. Two register stages, both advanced by the common pipeline enable.
`default_nettype none
module c2p_prep #(
    parameter int CW = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  wire                                  i_valid,
    input  wire  logic signed [CW-1:0]           i_x,
    input  wire  logic signed [CW-1:0]           i_y,
    output c2p_pkg::t_ctl                        o_ctl,
    output logic [2*CW-1:0]                      o_sum,
    output logic signed [c2p_pkg::CORDIC_W-1:0]  o_cx,
    output logic signed [c2p_pkg::CORDIC_W-1:0]  o_cy,
    output logic [c2p_pkg::ACC_W-1:0]            o_acc
);
    import c2p_pkg::*;

    localparam int UP = FULL_SCALE_LOG2 - (CW - 1);

    logic [CW-1:0]               n_ax;
    logic [CW-1:0]               n_ay;
    logic signed [CORDIC_W-1:0]  n_xe;
    logic signed [CORDIC_W-1:0]  n_ye;
    logic                        n_neg;
    t_ctl                        n_ctl;

    t_ctl                        r_ctl1;
    logic [2*CW-1:0]             r_sqx;
    logic [2*CW-1:0]             r_sqy;
    logic signed [CORDIC_W-1:0]  r_cx1;
    logic signed [CORDIC_W-1:0]  r_cy1;
    logic [ACC_W-1:0]            r_acc1;

    t_ctl                        r_ctl2;
    logic [2*CW-1:0]             r_sum;
    logic signed [CORDIC_W-1:0]  r_cx2;
    logic signed [CORDIC_W-1:0]  r_cy2;
    logic [ACC_W-1:0]            r_acc2;

    // Magnitudes, sign extension and the classification of points on an axis.
    always_comb begin
        n_ax  = i_x[CW-1] ? CW'(~$unsigned(i_x) + 1'b1) : $unsigned(i_x);
        n_ay  = i_y[CW-1] ? CW'(~$unsigned(i_y) + 1'b1) : $unsigned(i_y);
        n_xe  = CORDIC_W'(i_x);
        n_ye  = CORDIC_W'(i_y);
        n_neg = i_x[CW-1];
        n_ctl.valid = i_valid;
        if (i_x == '0 && i_y == '0) begin
            n_ctl.kind = KIND_ZERO;
        end else if (i_y == '0) begin
            n_ctl.kind = n_neg ? KIND_HALF : KIND_ZERO;
        end else if (i_x == '0) begin
            n_ctl.kind = i_y[CW-1] ? KIND_THREEQ : KIND_QUARTER;
        end else begin
            n_ctl.kind = KIND_CORDIC;
        end
    end

    // First stage: the two squares and the folded, scaled start vector.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl1 <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx  <= (2*CW)'(n_ax) * (2*CW)'(n_ax);
            r_sqy  <= (2*CW)'(n_ay) * (2*CW)'(n_ay);
            r_cx1  <= (n_neg ? -n_xe : n_xe) <<< UP;
            r_cy1  <= (n_neg ? -n_ye : n_ye) <<< UP;
            r_acc1 <= n_neg ? TURN_HALF : TURN_ZERO;
        end
    end

    // Second stage: the radicand; the CORDIC vector waits alongside.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= r_sqx + r_sqy;
            r_cx2  <= r_cx1;
            r_cy2  <= r_cy1;
            r_acc2 <= r_acc1;
        end
    end

    assign o_ctl = r_ctl2;
    assign o_sum = r_sum;
    assign o_cx  = r_cx2;
    assign o_cy  = r_cy2;
    assign o_acc = r_acc2;

endmodule
`default_nettype wire

FILE: src/c2p_iter.sv
// One iteration stage: a CORDIC vectoring micro-rotation and one digit of the square root.
// It depends on c2p_pkg. Either half passes its data through unchanged beyond its own count.
`default_nettype none
module c2p_iter #(
    parameter int CW     = 16,
    parameter int IDX    = 0,
    parameter int STAGES = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  wire  c2p_pkg::t_ctl                  i_ctl,
    input  wire  logic [2*CW-1:0]                i_sum,
    input  wire  logic [CW+2:0]                  i_rem,
    input  wire  logic [CW-1:0]                  i_root,
    input  wire  logic signed [c2p_pkg::CORDIC_W-1:0] i_cx,
    input  wire  logic signed [c2p_pkg::CORDIC_W-1:0] i_cy,
    input  wire  logic [c2p_pkg::ACC_W-1:0]      i_acc,
    output c2p_pkg::t_ctl                        o_ctl,
    output logic [2*CW-1:0]                      o_sum,
    output logic [CW+2:0]                        o_rem,
    output logic [CW-1:0]                        o_root,
    output logic signed [c2p_pkg::CORDIC_W-1:0]  o_cx,
    output logic signed [c2p_pkg::CORDIC_W-1:0]  o_cy,
    output logic [c2p_pkg::ACC_W-1:0]            o_acc
);
    import c2p_pkg::*;

    localparam int  RW        = CW + 3;
    localparam bit  DO_CORDIC = (IDX < STAGES);
    localparam bit  DO_SQRT   = (IDX < CW);

    logic [2*CW-1:0]             n_sum;
    logic [RW-1:0]               n_rem;
    logic [CW-1:0]               n_root;
    logic signed [CORDIC_W-1:0]  n_cx;
    logic signed [CORDIC_W-1:0]  n_cy;
    logic [ACC_W-1:0]            n_acc;

    t_ctl                        r_ctl;
    logic [2*CW-1:0]             r_sum;
    logic [RW-1:0]               r_rem;
    logic [CW-1:0]               r_root;
    logic signed [CORDIC_W-1:0]  r_cx;
    logic signed [CORDIC_W-1:0]  r_cy;
    logic [ACC_W-1:0]            r_acc;

    // Square root digit: bring down the next two radicand bits and try to subtract 4r+1.
    generate
        if (DO_SQRT) begin : g_sqrt
            logic [RW-1:0] w_part;
            logic [RW-1:0] w_trial;
            always_comb begin
                w_part  = {i_rem[RW-3:0], i_sum[2*CW-1:2*CW-2]};
                w_trial = RW'({i_root, 2'b01});
                n_sum   = i_sum << 2;
                if (w_part >= w_trial) begin
                    n_rem  = w_part - w_trial;
                    n_root = {i_root[CW-2:0], 1'b1};
                end else begin
                    n_rem  = w_part;
                    n_root = {i_root[CW-2:0], 1'b0};
                end
            end
        end else begin : g_sqrt_pass
            always_comb begin
                n_sum  = i_sum;
                n_rem  = i_rem;
                n_root = i_root;
            end
        end
    endgenerate

    // Micro-rotation towards the x axis: the sign of y picks the direction.
    generate
        if (DO_CORDIC) begin : g_cordic
            logic signed [CORDIC_W-1:0] w_dx;
            logic signed [CORDIC_W-1:0] w_dy;
            logic [ACC_W-1:0]           w_step;
            always_comb begin
                w_dx   = i_cy >>> IDX;
                w_dy   = i_cx >>> IDX;
                w_step = atan_turn(5'(IDX));
                if (!i_cy[CORDIC_W-1]) begin
                    n_cx  = i_cx + w_dx;
                    n_cy  = i_cy - w_dy;
                    n_acc = i_acc + w_step;
                end else begin
                    n_cx  = i_cx - w_dx;
                    n_cy  = i_cy + w_dy;
                    n_acc = i_acc - w_step;
                end
            end
        end else begin : g_cordic_pass
            always_comb begin
                n_cx  = i_cx;
                n_cy  = i_cy;
                n_acc = i_acc;
            end
        end
    endgenerate

    // Stage registers; only the valid bit is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= n_sum;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_acc  <= n_acc;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_sum  = r_sum;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_cx   = r_cx;
    assign o_cy   = r_cy;
    assign o_acc  = r_acc;

endmodule
`default_nettype wire

FILE: src/c2p_post.sv
// Output stage: rounds the radius and the angle and holds the result for the master side.
// It depends on c2p_pkg. Its register is the output register of the converter.
`default_nettype none
module c2p_post #(
    parameter int CW = 16,
    parameter int AW = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire  c2p_pkg::t_ctl              i_ctl,
    input  wire  logic [CW+2:0]              i_rem,
    input  wire  logic [CW-1:0]              i_root,
    input  wire  logic [c2p_pkg::ACC_W-1:0]  i_acc,
    output logic                             o_valid,
    output logic [CW-1:0]                    o_radius,
    output logic [AW-1:0]                    o_angle
);
    import c2p_pkg::*;

    localparam int DROP = ACC_W - AW;

    logic [ACC_W-1:0] n_turns;
    logic [CW-1:0]    n_radius;
    logic [AW-1:0]    n_angle;

    logic             r_valid;
    logic [CW-1:0]    r_radius;
    logic [AW-1:0]    r_angle;

    // Round the root up when the remainder exceeds it; a tie cannot occur.
    always_comb begin
        n_radius = (i_rem > (CW+3)'(i_root)) ? i_root + 1'b1 : i_root;
    end

    // Axis points take their exact angle, all others the CORDIC accumulator.
    always_comb begin
        case (i_ctl.kind)
            KIND_ZERO:    n_turns = TURN_ZERO;
            KIND_HALF:    n_turns = TURN_HALF;
            KIND_QUARTER: n_turns = TURN_QUARTER;
            KIND_THREEQ:  n_turns = TURN_THREEQ;
            default:      n_turns = i_acc;
        endcase
    end

    // Round half up to a narrower output angle width, wrapping modulo a full turn.
    generate
        if (DROP > 0) begin : g_round
            logic [ACC_W-1:0] w_biased;
            always_comb begin
                w_biased = n_turns + (ACC_W'(1) << (DROP - 1));
                n_angle  = w_biased[ACC_W-1:DROP];
            end
        end else begin : g_full
            always_comb begin
                n_angle = n_turns;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_radius <= n_radius;
            r_angle  <= n_angle;
        end
    end

    assign o_valid  = r_valid;
    assign o_radius = r_radius;
    assign o_angle  = r_angle;

endmodule
`default_nettype wire

FILE: src/cartesian_to_polar.sv
// Top level of the Cartesian-to-polar converter: stream ports and the chain of stages.
// It depends on c2p_pkg, c2p_prep, c2p_iter and c2p_post.
//
// The converter takes one signed point per transfer and returns the rounded radius and the
// angle in binary angle units (2^ANGLE_WIDTH units per turn, counterclockwise from the
// positive x axis). It accepts a new point in every cycle in which the pipeline is not stalled;
// each result passes through two front-end stages (squares and their sum), one iteration
// stage per CORDIC step or square root digit, and the output register. All stages advance
// together: while a result waits in the output register and the master side holds tready low,
// the whole pipeline and the slave side stall, and no item is lost or repeated. The angle lies
// within one unit of the exactly rounded value.
`default_nettype none
module cartesian_to_polar #(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16,
    parameter int STAGES      = 16
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  wire                                          i_s_tvalid,
    output logic                                         o_s_tready,
    // Fields from bit 0 up: x_coord, y_coord, zero padding.
    input  wire  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    output logic                                         o_m_tvalid,
    input  wire                                          i_m_tready,
    // Fields from bit 0 up: radius, angle, zero padding.
    output logic [((COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] o_m_tdata
);
    import c2p_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int RW     = CW + 3;
    localparam int NSTEP  = (CW > STAGES) ? CW : STAGES;
    localparam int OUT_W  = ((COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;
    localparam int PAD_W  = OUT_W - COORD_WIDTH - ANGLE_WIDTH;

    logic                        w_en;
    logic signed [CW-1:0]        w_x;
    logic signed [CW-1:0]        w_y;
    logic [CW-1:0]               w_radius;
    logic [ANGLE_WIDTH-1:0]      w_angle;

    t_ctl                        w_ctl  [NSTEP+1];
    logic [2*CW-1:0]             w_sum  [NSTEP+1];
    logic [RW-1:0]               w_rem  [NSTEP+1];
    logic [CW-1:0]               w_root [NSTEP+1];
    logic signed [CORDIC_W-1:0]  w_cx   [NSTEP+1];
    logic signed [CORDIC_W-1:0]  w_cy   [NSTEP+1];
    logic [ACC_W-1:0]            w_acc  [NSTEP+1];

    // The pipeline moves whenever the output register is empty or being read.
    assign w_en       = ~o_m_tvalid | i_m_tready;
    assign o_s_tready = w_en;

    assign w_x = $signed(i_s_tdata[CW-1:0]);
    assign w_y = $signed(i_s_tdata[2*CW-1:CW]);

    c2p_prep #(
        .CW (CW)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_x     (w_x),
        .i_y     (w_y),
        .o_ctl   (w_ctl[0]),
        .o_sum   (w_sum[0]),
        .o_cx    (w_cx[0]),
        .o_cy    (w_cy[0]),
        .o_acc   (w_acc[0])
    );

    // The square root starts with an empty remainder and root.
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    // Chain of iteration stages.
    generate
        for (genvar k = 0; k < NSTEP; k++) begin : g_iter
            c2p_iter #(
                .CW     (CW),
                .IDX    (k),
                .STAGES (STAGES)
            ) u_iter (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_ctl   (w_ctl[k]),
                .i_sum   (w_sum[k]),
                .i_rem   (w_rem[k]),
                .i_root  (w_root[k]),
                .i_cx    (w_cx[k]),
                .i_cy    (w_cy[k]),
                .i_acc   (w_acc[k]),
                .o_ctl   (w_ctl[k+1]),
                .o_sum   (w_sum[k+1]),
                .o_rem   (w_rem[k+1]),
                .o_root  (w_root[k+1]),
                .o_cx    (w_cx[k+1]),
                .o_cy    (w_cy[k+1]),
                .o_acc   (w_acc[k+1])
            );
        end
    endgenerate

    c2p_post #(
        .CW (CW),
        .AW (ANGLE_WIDTH)
    ) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (w_ctl[NSTEP]),
        .i_rem    (w_rem[NSTEP]),
        .i_root   (w_root[NSTEP]),
        .i_acc    (w_acc[NSTEP]),
        .o_valid  (o_m_tvalid),
        .o_radius (w_radius),
        .o_angle  (w_angle)
    );

    // Pack the result transfer, padding with zeros to whole bytes.
    generate
        if (PAD_W > 0) begin : g_pad
            assign o_m_tdata = {PAD_W'(0), w_angle, w_radius};
        end else begin : g_nopad
            assign o_m_tdata = {w_angle, w_radius};
        end
    endgenerate

endmodule
`default_nettype wire
